// File: sv/zpf_pkg.sv
// ----------------------------------------------------------------------------
// zpf_pkg
// shared types, constants and helpers of the zero-phase iir filter
// ----------------------------------------------------------------------------
package zpf_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int MAX_TAPS_DEF    = 8;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_FRAC_BITS  = 12;
  localparam int PAD_FACTOR      = 3;
  localparam int REFLECT_GAIN    = 2;
  localparam int COEF_W          = 16;
  localparam int DATA_W          = 32;
  localparam int PROD_W          = COEF_W + DATA_W;
  localparam int ACC_W           = 56;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int TAP_CNT_W       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT = 3'd0,
    CFG_NUM_LOW   = 3'd1,
    CFG_NUM_HIGH  = 3'd2,
    CFG_DEN_LOW   = 3'd3,
    CFG_DEN_HIGH  = 3'd4,
    CFG_ZI_LOW    = 3'd5,
    CFG_ZI_HIGH   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_OVF   = 2'd2
  } status_t;

  // where the filter input value of the current step comes from
  typedef enum logic [1:0] {
    SRC_PLAIN = 2'd0,
    SRC_FRONT = 2'd1,
    SRC_BACK  = 2'd2,
    SRC_FWD   = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    TERM_B    = 2'd0,
    TERM_A    = 2'd1,
    TERM_Z    = 2'd2,
    TERM_NONE = 2'd3
  } term_t;

  typedef struct packed {
    logic  push_we;
    logic  first_we;
    logic  in_rd;
    logic  fwd_rd;
    logic  fwd_we;
    logic  out_rd;
    logic  out_we;
    logic  hist_clr;
    logic  hist_sh;
    logic  load_u;
    logic  set_x0;
    logic  mul_en;
    logic  round_en;
    src_t  src;
    term_t term;
  } dp_cmd_t;

  // signed q3.12 halfword j of a pair of packed 64-bit registers
  function automatic logic signed [COEF_W-1:0] coef_half(
    input logic [CFG_W-1:0] lo,
    input logic [CFG_W-1:0] hi,
    input logic [2:0]       j
  );
    logic [CFG_W-1:0] r;
    r = j[2] ? hi : lo;
    return $signed(r[{j[1:0], 4'd0} +: COEF_W]);
  endfunction

endpackage

// File: sv/zpf_if.sv
// ----------------------------------------------------------------------------
// zpf item channels
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface zpf_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     func;
  logic signed [zpf_pkg::SAMPLE_WIDTH-1:0]  sample_in;
  logic                                     end_of_record;

  modport source (output valid, func, sample_in, end_of_record, input ready);
  modport sink   (input valid, func, sample_in, end_of_record, output ready);
endinterface

interface zpf_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [zpf_pkg::SAMPLE_WIDTH-1:0]  filtered_sample;
  logic                                     final_sample;
  logic                                     has_data;
  logic [1:0]                               status;

  modport source (output valid, filtered_sample, final_sample, has_data, status,
                  input ready);
  modport sink   (input valid, filtered_sample, final_sample, has_data, status,
                  output ready);
endinterface

// File: sv/zpf_dp.sv
// ----------------------------------------------------------------------------
// zpf_dp
// datapath: config registers, sample memories, histories and shared mac
// ----------------------------------------------------------------------------
module zpf_dp #(
  parameter int MAX_SAMPLES = zpf_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_TAPS    = zpf_pkg::MAX_TAPS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [zpf_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [zpf_pkg::CFG_W-1:0]                cfg_data,
  input  zpf_pkg::dp_cmd_t                         cmd,
  input  logic signed [zpf_pkg::SAMPLE_WIDTH-1:0]  sample_in,
  input  logic [$clog2(MAX_SAMPLES)-1:0]           in_addr,
  input  logic [$clog2(MAX_SAMPLES+zpf_pkg::PAD_FACTOR*(MAX_TAPS-1))-1:0] fwd_addr,
  input  logic [$clog2(MAX_SAMPLES)-1:0]           out_addr,
  input  logic [$clog2(MAX_TAPS)-1:0]              tap_idx,
  output logic [zpf_pkg::TAP_CNT_W-1:0]            tap_count,
  output logic signed [zpf_pkg::SAMPLE_WIDTH-1:0]  out_sample
);

  localparam int PAD_MAX = zpf_pkg::PAD_FACTOR * (MAX_TAPS - 1);
  localparam int SW      = zpf_pkg::SAMPLE_WIDTH;
  localparam int DW      = zpf_pkg::DATA_W;
  localparam int AW      = zpf_pkg::ACC_W;
  localparam int F       = zpf_pkg::COEF_FRAC_BITS;
  localparam int MW      = $clog2(MAX_TAPS);

  logic [zpf_pkg::CFG_W-1:0] num_lo, num_hi, den_lo, den_hi, zi_lo, zi_hi;

  logic signed [SW-1:0] in_mem  [MAX_SAMPLES];
  logic signed [DW-1:0] fwd_mem [MAX_SAMPLES+PAD_MAX];
  logic signed [DW-1:0] out_mem [MAX_SAMPLES];
  logic signed [SW-1:0] in_q, first_s, last_s;
  logic signed [DW-1:0] fwd_q, out_q;

  logic signed [DW-1:0] xh [MAX_TAPS];
  logic signed [DW-1:0] yh [MAX_TAPS];
  logic signed [DW-1:0] x0, yr, u, op;
  logic signed [SW+1:0] u_int;
  logic signed [zpf_pkg::COEF_W-1:0] coef;
  logic signed [zpf_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0] acc, rnd_sum, rnd_sh, y_sat;
  logic signed [DW:0]   o_sum, o_sh;
  logic                 pend, neg;
  logic [2:0]           idx3;
  logic [MW-1:0]        idx_m1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= zpf_pkg::TAP_CNT_W'(2);
      num_lo    <= zpf_pkg::CFG_W'(4096);
      num_hi    <= '0;
      den_lo    <= '0;
      den_hi    <= '0;
      zi_lo     <= '0;
      zi_hi     <= '0;
    end else if (cfg_we) begin
      case (zpf_pkg::cfg_reg_t'(cfg_index))
        zpf_pkg::CFG_TAP_COUNT: tap_count <= cfg_data[zpf_pkg::TAP_CNT_W-1:0];
        zpf_pkg::CFG_NUM_LOW:   num_lo    <= cfg_data;
        zpf_pkg::CFG_NUM_HIGH:  num_hi    <= cfg_data;
        zpf_pkg::CFG_DEN_LOW:   den_lo    <= cfg_data;
        zpf_pkg::CFG_DEN_HIGH:  den_hi    <= cfg_data;
        zpf_pkg::CFG_ZI_LOW:    zi_lo     <= cfg_data;
        zpf_pkg::CFG_ZI_HIGH:   zi_hi     <= cfg_data;
        default: ;
      endcase
    end
  end

  // record memory
  always_ff @(posedge clk) begin
    if (cmd.push_we) in_mem[in_addr] <= sample_in;
    if (cmd.in_rd) in_q <= in_mem[in_addr];
    if (cmd.push_we) last_s <= sample_in;
    if (cmd.first_we) first_s <= sample_in;
  end

  // forward pass results
  always_ff @(posedge clk) begin
    if (cmd.fwd_we) fwd_mem[fwd_addr] <= yr;
    if (cmd.fwd_rd) fwd_q <= fwd_mem[fwd_addr];
  end

  // final results
  always_ff @(posedge clk) begin
    if (cmd.out_we) out_mem[out_addr] <= yr;
    if (cmd.out_rd) out_q <= out_mem[out_addr];
  end

  // filter input value, reflected padding at both ends
  always_comb begin
    case (cmd.src)
      zpf_pkg::SRC_FRONT:
        u_int = (SW+2)'(zpf_pkg::REFLECT_GAIN) * (SW+2)'(first_s) - (SW+2)'(in_q);
      zpf_pkg::SRC_BACK:
        u_int = (SW+2)'(zpf_pkg::REFLECT_GAIN) * (SW+2)'(last_s) - (SW+2)'(in_q);
      default:
        u_int = (SW+2)'(in_q);
    endcase
    if (cmd.src == zpf_pkg::SRC_FWD) u = fwd_q;
    else u = DW'(u_int) <<< F;
  end

  assign idx3   = 3'(tap_idx);
  assign idx_m1 = tap_idx - MW'(1);

  always_comb begin
    case (cmd.term)
      zpf_pkg::TERM_B: begin
        coef = zpf_pkg::coef_half(num_lo, num_hi, idx3);
        op   = xh[tap_idx];
      end
      zpf_pkg::TERM_A: begin
        coef = zpf_pkg::coef_half(den_lo, den_hi, idx3);
        op   = yh[idx_m1];
      end
      zpf_pkg::TERM_Z: begin
        coef = zpf_pkg::coef_half(zi_lo, zi_hi, idx3);
        op   = x0;
      end
      default: begin
        coef = '0;
        op   = '0;
      end
    endcase
  end

  // round half up to F fraction bits, saturate to 32 bits
  always_comb begin
    rnd_sum = acc + (AW'(1) <<< (F - 1));
    rnd_sh  = rnd_sum >>> F;
    if (rnd_sh > AW'(32'sh7fff_ffff)) y_sat = AW'(32'sh7fff_ffff);
    else if (rnd_sh < -(AW'(1) <<< (DW - 1))) y_sat = -(AW'(1) <<< (DW - 1));
    else y_sat = rnd_sh;
  end

  // histories and mac
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.mul_en && (cmd.term != zpf_pkg::TERM_NONE);
    end
    prod <= coef * op;
    neg  <= (cmd.term == zpf_pkg::TERM_A);
    if (cmd.load_u) acc <= '0;
    else if (pend) acc <= neg ? acc - AW'(prod) : acc + AW'(prod);
    if (cmd.round_en) yr <= DW'(y_sat);
    if (cmd.set_x0) x0 <= u;
    if (cmd.hist_clr) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else begin
      if (cmd.load_u) begin
        xh[0] <= u;
        for (int i = 1; i < MAX_TAPS; i++) xh[i] <= xh[i-1];
      end
      if (cmd.hist_sh) begin
        yh[0] <= yr;
        for (int i = 1; i < MAX_TAPS; i++) yh[i] <= yh[i-1];
      end
    end
  end

  // read-out rounding to an integer sample
  always_comb begin
    o_sum = (DW+1)'(out_q) + ((DW+1)'(1) <<< (F - 1));
    o_sh  = o_sum >>> F;
    if (o_sh > (DW+1)'((1 <<< (SW - 1)) - 1)) out_sample = SW'((1 <<< (SW - 1)) - 1);
    else if (o_sh < -((DW+1)'(1) <<< (SW - 1))) out_sample = SW'(-(1 <<< (SW - 1)));
    else out_sample = SW'(o_sh);
  end

endmodule

// File: sv/zpf_ctrl.sv
// ----------------------------------------------------------------------------
// zpf_ctrl
// controller: record bookkeeping, two-pass sequencer and result register
// ----------------------------------------------------------------------------
module zpf_ctrl #(
  parameter int MAX_SAMPLES = zpf_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_TAPS    = zpf_pkg::MAX_TAPS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_func,
  input  logic                                     in_eor,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [zpf_pkg::SAMPLE_WIDTH-1:0]  out_sample_q,
  output logic                                     out_final,
  output logic                                     out_has,
  output logic [1:0]                               out_status,
  output zpf_pkg::dp_cmd_t                         cmd,
  output logic [$clog2(MAX_SAMPLES)-1:0]           in_addr,
  output logic [$clog2(MAX_SAMPLES+zpf_pkg::PAD_FACTOR*(MAX_TAPS-1))-1:0] fwd_addr,
  output logic [$clog2(MAX_SAMPLES)-1:0]           out_addr,
  output logic [$clog2(MAX_TAPS)-1:0]              tap_idx,
  input  logic [zpf_pkg::TAP_CNT_W-1:0]            tap_count,
  input  logic signed [zpf_pkg::SAMPLE_WIDTH-1:0]  dp_sample
);

  localparam int PAD_MAX = zpf_pkg::PAD_FACTOR * (MAX_TAPS - 1);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int LW  = $clog2(MAX_SAMPLES + 2);
  localparam int FAW = $clog2(MAX_SAMPLES + PAD_MAX);
  localparam int MW  = $clog2(MAX_TAPS);
  localparam int PW  = $clog2(PAD_MAX + 1);
  localparam int XW  = $clog2(2 * MAX_SAMPLES + 3 * PAD_MAX + 2);
  localparam int TCW = MW + 1;
  localparam int TNW = zpf_pkg::TAP_CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_LD, S_MAC, S_DRAIN, S_RND, S_WB, S_OUT
  } state_t;

  state_t          state;
  logic [LW-1:0]   len, rp, len_eff, len_new;
  logic            ready, closed, pass;
  logic [1:0]      status;
  logic [MW-1:0]   m, m_new;
  logic [PW-1:0]   p, p_new;
  logic [TNW-1:0]  taps;
  logic [XW-1:0]   k, nx, px, k_end;
  logic [TCW-1:0]  t, mt;
  logic            accept, has;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign len_eff  = closed ? '0 : len;
  assign len_new  = (len_eff < LW'(MAX_SAMPLES)) ? len_eff + LW'(1) : LW'(MAX_SAMPLES + 1);

  always_comb begin
    if (tap_count < TNW'(2)) taps = TNW'(2);
    else if (tap_count > TNW'(MAX_TAPS)) taps = TNW'(MAX_TAPS);
    else taps = tap_count;
  end
  assign m_new = MW'(taps - TNW'(1));
  assign p_new = PW'(zpf_pkg::PAD_FACTOR * (taps - TNW'(1)));

  assign nx    = XW'(len);
  assign px    = XW'(p);
  assign mt    = TCW'(m);
  assign k_end = pass ? nx + px - XW'(1) : nx + (px << 1) - XW'(1);
  assign has   = ready && (rp < len) && (len <= LW'(MAX_SAMPLES));

  // commands and addresses
  always_comb begin
    cmd      = '0;
    cmd.src  = zpf_pkg::SRC_PLAIN;
    cmd.term = zpf_pkg::TERM_NONE;
    in_addr  = AW'(len_eff);
    fwd_addr = FAW'(k - px);
    out_addr = AW'(rp);
    tap_idx  = '0;
    // where the current step's input comes from
    if (pass) begin
      cmd.src  = zpf_pkg::SRC_FWD;
      fwd_addr = FAW'(nx + px - XW'(1) - k);
    end else if (k < px) begin
      cmd.src = zpf_pkg::SRC_FRONT;
      in_addr = AW'(px - k);
    end else if (k < px + nx) begin
      cmd.src = zpf_pkg::SRC_PLAIN;
      in_addr = AW'(k - px);
    end else begin
      cmd.src = zpf_pkg::SRC_BACK;
      in_addr = AW'((nx << 1) + px - XW'(2) - k);
    end
    case (state)
      S_IDLE: begin
        in_addr = AW'(len_eff);
        if (accept && !in_func) begin
          cmd.push_we  = (len_eff < LW'(MAX_SAMPLES));
          cmd.first_we = (len_eff == '0);
          cmd.hist_clr = 1'b1;
        end
        cmd.out_rd = accept && in_func;
      end
      S_RD: begin
        cmd.in_rd  = !pass;
        cmd.fwd_rd = pass;
      end
      S_LD: begin
        cmd.load_u = 1'b1;
        cmd.set_x0 = (k == '0);
      end
      S_MAC: begin
        cmd.mul_en = 1'b1;
        if (t <= mt) begin
          cmd.term = zpf_pkg::TERM_B;
          tap_idx  = MW'(t);
        end else if (t <= (mt << 1)) begin
          cmd.term = zpf_pkg::TERM_A;
          tap_idx  = MW'(t - mt);
        end else if (k < XW'(m)) begin
          cmd.term = zpf_pkg::TERM_Z;
          tap_idx  = MW'(k);
        end
      end
      S_RND: cmd.round_en = 1'b1;
      S_WB: begin
        // history shifts on every step, memory write only past the padding
        cmd.fwd_we   = !pass && (k >= px);
        cmd.out_we   = pass && (k >= px);
        cmd.hist_sh  = 1'b1;
        // the backward pass starts from empty histories
        cmd.hist_clr = !pass && (k == k_end);
        out_addr     = AW'(nx + px - XW'(1) - k);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rp        <= '0;
      ready     <= 1'b0;
      closed    <= 1'b0;
      status    <= zpf_pkg::ST_OK;
      pass      <= 1'b0;
      k         <= '0;
      t         <= '0;
      m         <= '0;
      p         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && !in_func) begin
            len <= len_new;
            if (in_eor) begin
              closed <= 1'b1;
              rp     <= '0;
              ready  <= 1'b0;
              m      <= m_new;
              p      <= p_new;
              pass   <= 1'b0;
              k      <= '0;
              if (len_new > LW'(MAX_SAMPLES)) begin
                status <= zpf_pkg::ST_OVF;
              end else if (XW'(len_new) <= XW'(p_new)) begin
                status <= zpf_pkg::ST_SHORT;
              end else begin
                status <= zpf_pkg::ST_OK;
                state  <= S_RD;
              end
            end else if (closed) begin
              closed <= 1'b0;
              rp     <= '0;
              ready  <= 1'b0;
              status <= zpf_pkg::ST_OK;
            end
          end else if (accept) begin
            state <= S_OUT;
          end
        end
        S_RD: state <= S_LD;
        S_LD: begin
          t     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          t <= t + TCW'(1);
          if (t == (mt << 1) + TCW'(1)) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_RND;
        S_RND:   state <= S_WB;
        S_WB: begin
          if (k == k_end) begin
            k <= '0;
            if (!pass) begin
              pass  <= 1'b1;
              state <= S_RD;
            end else begin
              ready <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            k     <= k + XW'(1);
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_has      <= has;
            out_sample_q <= has ? dp_sample : '0;
            out_final    <= has && (rp + LW'(1) == len);
            out_status   <= status;
            if (has) begin
              rp <= rp + LW'(1);
              if (rp + LW'(1) == len) ready <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/zero_phase_iir_filter_top.sv
// ----------------------------------------------------------------------------
// zero_phase_iir_filter_top
// forward-backward (zero-phase) iir filter over one record of samples
// ----------------------------------------------------------------------------
// push items are taken while idle; a read item moves to S_OUT, which registers
// its result, and waits there while an earlier result is not yet taken
// closing a record that is neither too short nor too long runs a forward pass
// over n+2p steps and a backward pass over n+p steps, p = 3*(taps-1), all on
// the one mac; no item is taken until both passes are done and reads give data
// reset is synchronous: config returns to defaults, record state clears,
// sample memories keep their contents and are only read after being written
module zero_phase_iir_filter_top #(
  parameter int MAX_SAMPLES = zpf_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_TAPS    = zpf_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  zpf_in_if.sink                        in_ch,
  zpf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [zpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zpf_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PAD_MAX = zpf_pkg::PAD_FACTOR * (MAX_TAPS - 1);

  // command and status between sequencer and datapath
  zpf_pkg::dp_cmd_t                          cmd;
  logic [$clog2(MAX_SAMPLES)-1:0]            in_addr;
  logic [$clog2(MAX_SAMPLES+PAD_MAX)-1:0]    fwd_addr;
  logic [$clog2(MAX_SAMPLES)-1:0]            out_addr;
  logic [$clog2(MAX_TAPS)-1:0]               tap_idx;
  logic [zpf_pkg::TAP_CNT_W-1:0]             tap_count;
  logic signed [zpf_pkg::SAMPLE_WIDTH-1:0]   dp_sample;

  // sequencer: record length, read pointer, status, pass/step counters
  zpf_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_TAPS    (MAX_TAPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_func      (in_ch.func),
    .in_eor       (in_ch.end_of_record),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_sample_q (out_ch.filtered_sample),
    .out_final    (out_ch.final_sample),
    .out_has      (out_ch.has_data),
    .out_status   (out_ch.status),
    .cmd          (cmd),
    .in_addr      (in_addr),
    .fwd_addr     (fwd_addr),
    .out_addr     (out_addr),
    .tap_idx      (tap_idx),
    .tap_count    (tap_count),
    .dp_sample    (dp_sample)
  );

  // datapath: coefficients, memories, tap histories, mac and rounding
  zpf_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_TAPS    (MAX_TAPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sample_in  (in_ch.sample_in),
    .in_addr    (in_addr),
    .fwd_addr   (fwd_addr),
    .out_addr   (out_addr),
    .tap_idx    (tap_idx),
    .tap_count  (tap_count),
    .out_sample (dp_sample)
  );

endmodule
